// ----- rtl/assert_macros.svh -----
// assertion macros shared by the rtl files that check their own logic
// no dependencies; define SYNTH to compile the checks away
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property must hold at every rising edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    `ASSERT_CLK(label, clk, rst_n, !(expr))

`else

`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

// ----- rtl/oale_pkg.sv -----
`timescale 1ns / 1ps
// types, codes and defaults for the ordered array list engine
// no dependencies; used by controller, datapath and top level

package oale_pkg;

    // default list capacity
    localparam int unsigned LIST_DEPTH_DEF = 256;

    // operation codes carried on s_tuser
    typedef enum logic [2:0] {
        MODE_INSERT = 3'd0,
        MODE_DELETE = 3'd1,
        MODE_WRITE  = 3'd2,
        MODE_SEARCH = 3'd3,
        MODE_READ   = 3'd4
    } mode_t;

    // result status carried on m_tuser
    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_BAD_POS   = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } status_t;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_INS_WALK,
        ST_INS_PUT,
        ST_DEL_WALK,
        ST_SRCH,
        ST_RD_WAIT,
        ST_RESULT
    } ctrl_state_t;

    // controller to datapath commands
    typedef struct packed {
        logic    load;       // take the input beat
        logic    step;       // read one entry at or next to the walk pointer, move it on
        logic    wr_shift;   // write the pending read data back one place over
        logic    wr_put;     // write the operand value at the position
        logic    inc_cnt;
        logic    dec_cnt;
        logic    cap_rd;     // keep read data as the result value
        logic    cap_idx;    // keep pending address as the found index
        logic    res_load;   // load the output register
        status_t res_status;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic [2:0] mode;
        logic       pos_gt_cnt;
        logic       pos_ge_cnt;
        logic       full;
        logic       walk_more;
        logic       pend_valid;
        logic       match;
        logic       out_free;
    } sts_t;

endpackage

// ----- rtl/oale_dpath.sv -----
`timescale 1ns / 1ps
// datapath: entry memory, walk pointer, operand, count and output registers
// depends on oale_pkg

module oale_dpath #(
    parameter int unsigned LIST_DEPTH = oale_pkg::LIST_DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [2:0]         in_mode,
    input  logic [7:0]         in_pos,
    input  logic signed [31:0] in_val,
    input  oale_pkg::cmd_t     cmd,
    output oale_pkg::sts_t     sts,
    input  logic               m_tready,
    output logic               m_tvalid,
    output logic [1:0]         m_status,
    output logic [7:0]         m_found_index,
    output logic signed [31:0] m_read_value,
    output logic [8:0]         m_entry_count
);

    localparam int unsigned ADDR_W = $clog2(LIST_DEPTH);
    localparam int unsigned CNT_W  = $clog2(LIST_DEPTH + 1);
    localparam int unsigned CMP_W  = (CNT_W > 8) ? CNT_W : 8;
    localparam int unsigned IDX_W  = (ADDR_W > 8) ? ADDR_W : 8;
    localparam int unsigned OCNT_W = (CNT_W > 9) ? CNT_W : 9;

    // entry memory, contents undefined until written
    logic signed [31:0] mem [LIST_DEPTH];

    logic [2:0]          mode_reg;
    logic [7:0]          pos_reg;
    logic signed [31:0]  val_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    ptr_reg, ptr_next;
    logic                pend_valid_reg;
    logic [ADDR_W-1:0]   pend_addr_reg;
    logic signed [31:0]  rdata_reg;
    logic [7:0]          idx_reg;
    logic signed [31:0]  rdv_reg;
    logic                m_tvalid_reg;
    oale_pkg::status_t   m_status_reg;
    logic [7:0]          m_idx_reg;
    logic signed [31:0]  m_rd_reg;
    logic [8:0]          m_cnt_reg;

    logic [CMP_W-1:0]    pos_cmp, cnt_cmp, ptr_cmp, ptr_inc_cmp;
    logic [CNT_W-1:0]    ptr_inc, ptr_dec, rd_ptr;
    logic [ADDR_W-1:0]   rd_addr, wr_addr;
    logic signed [31:0]  wr_data;
    logic                wr_en;
    logic                walk_more;
    logic [IDX_W-1:0]    pend_idx_ext;
    logic [OCNT_W-1:0]   cnt_ext;

    function automatic logic [CNT_W-1:0] ptr_inc_cnt(input logic [CNT_W-1:0] c);
        ptr_inc_cnt = c + CNT_W'(1);
    endfunction

    // compare operands on a common width
    assign ptr_inc     = ptr_reg + CNT_W'(1);
    assign ptr_dec     = ptr_reg - CNT_W'(1);
    assign pos_cmp     = CMP_W'(pos_reg);
    assign cnt_cmp     = CMP_W'(cnt_reg);
    assign ptr_cmp     = CMP_W'(ptr_reg);
    assign ptr_inc_cmp = CMP_W'(ptr_inc);

    // walk direction and read address by operation
    always_comb begin
        walk_more = 1'b0;
        rd_ptr    = ptr_reg;
        ptr_next  = ptr_inc;
        unique case (mode_reg)
            oale_pkg::MODE_INSERT: begin
                walk_more = (ptr_cmp > pos_cmp);
                rd_ptr    = ptr_dec;
                ptr_next  = ptr_dec;
            end
            oale_pkg::MODE_DELETE: begin
                walk_more = (ptr_inc_cmp < cnt_cmp);
                rd_ptr    = ptr_inc;
            end
            oale_pkg::MODE_SEARCH: begin
                walk_more = (ptr_cmp < cnt_cmp);
            end
            default: begin
                walk_more = 1'b0;
            end
        endcase
    end

    assign rd_addr = rd_ptr[ADDR_W-1:0];

    // single write port: shifted entry or operand value
    assign wr_en   = cmd.wr_shift | cmd.wr_put;
    assign wr_addr = cmd.wr_put ? ADDR_W'(pos_reg) : pend_addr_reg;
    assign wr_data = cmd.wr_put ? val_reg : rdata_reg;

    // memory write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.step) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // operand capture and walk pointer
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg <= in_mode;
            pos_reg  <= in_pos;
            val_reg  <= in_val;
            unique case (in_mode)
                oale_pkg::MODE_INSERT: ptr_reg <= cnt_reg;
                oale_pkg::MODE_SEARCH: ptr_reg <= '0;
                default:               ptr_reg <= CNT_W'(in_pos);
            endcase
        end else if (cmd.step) begin
            ptr_reg <= ptr_next;
        end
        if (cmd.step) begin
            pend_addr_reg <= ptr_reg[ADDR_W-1:0];
        end
    end

    // pending read marker, valid the cycle after a step
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
        end else begin
            pend_valid_reg <= cmd.step;
        end
    end

    // fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.inc_cnt) begin
            cnt_reg <= ptr_inc_cnt(cnt_reg);
        end else if (cmd.dec_cnt) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    // result index and read value
    assign pend_idx_ext = IDX_W'(pend_addr_reg);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            idx_reg <= in_pos;
            rdv_reg <= '0;
        end else begin
            if (cmd.cap_idx) begin
                idx_reg <= pend_idx_ext[7:0];
            end
            if (cmd.cap_rd) begin
                rdv_reg <= rdata_reg;
            end
        end
    end

    // output register
    assign cnt_ext = OCNT_W'(cnt_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.res_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.res_load) begin
            m_status_reg <= cmd.res_status;
            m_idx_reg    <= idx_reg;
            m_rd_reg     <= rdv_reg;
            m_cnt_reg    <= cnt_ext[8:0];
        end
    end

    assign m_tvalid      = m_tvalid_reg;
    assign m_status      = m_status_reg;
    assign m_found_index = m_idx_reg;
    assign m_read_value  = m_rd_reg;
    assign m_entry_count = m_cnt_reg;

    // status towards the controller
    always_comb begin
        sts            = '0;
        sts.mode       = mode_reg;
        sts.pos_gt_cnt = (pos_cmp > cnt_cmp);
        sts.pos_ge_cnt = (pos_cmp >= cnt_cmp);
        sts.full       = (cnt_reg == CNT_W'(LIST_DEPTH));
        sts.walk_more  = walk_more;
        sts.pend_valid = pend_valid_reg;
        sts.match      = (rdata_reg == val_reg);
        sts.out_free   = !m_tvalid_reg || m_tready;
    end

endmodule

// ----- rtl/oale_ctrl.sv -----
`timescale 1ns / 1ps
// controller: sequences one operation at a time over the datapath
// depends on oale_pkg

module oale_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  oale_pkg::sts_t sts,
    output oale_pkg::cmd_t cmd
);

    oale_pkg::ctrl_state_t state_reg, state_next;
    oale_pkg::status_t     status_reg, status_next;

    // state and status registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= oale_pkg::ST_IDLE;
            status_reg <= oale_pkg::STAT_OK;
        end else begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next     = state_reg;
        status_next    = status_reg;
        cmd            = '0;
        cmd.res_status = status_reg;
        s_tready       = 1'b0;
        unique case (state_reg)
            oale_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = oale_pkg::ST_DECODE;
                end
            end
            oale_pkg::ST_DECODE: begin
                status_next = oale_pkg::STAT_OK;
                state_next  = oale_pkg::ST_RESULT;
                unique case (sts.mode)
                    oale_pkg::MODE_INSERT: begin
                        if (sts.pos_gt_cnt) begin
                            status_next = oale_pkg::STAT_BAD_POS;
                        end else if (sts.full) begin
                            status_next = oale_pkg::STAT_FULL;
                        end else begin
                            state_next = oale_pkg::ST_INS_WALK;
                        end
                    end
                    oale_pkg::MODE_DELETE: begin
                        if (sts.pos_ge_cnt) begin
                            status_next = oale_pkg::STAT_BAD_POS;
                        end else begin
                            state_next = oale_pkg::ST_DEL_WALK;
                        end
                    end
                    oale_pkg::MODE_WRITE: begin
                        if (sts.pos_ge_cnt) begin
                            status_next = oale_pkg::STAT_BAD_POS;
                        end else begin
                            cmd.wr_put = 1'b1;
                        end
                    end
                    oale_pkg::MODE_SEARCH: begin
                        state_next = oale_pkg::ST_SRCH;
                    end
                    oale_pkg::MODE_READ: begin
                        if (sts.pos_ge_cnt) begin
                            status_next = oale_pkg::STAT_BAD_POS;
                        end else begin
                            cmd.step   = 1'b1;
                            state_next = oale_pkg::ST_RD_WAIT;
                        end
                    end
                    default: begin
                        state_next = oale_pkg::ST_RESULT;
                    end
                endcase
            end
            // move entries up one place, top first
            oale_pkg::ST_INS_WALK: begin
                cmd.wr_shift = sts.pend_valid;
                if (sts.walk_more) begin
                    cmd.step = 1'b1;
                end else begin
                    state_next = oale_pkg::ST_INS_PUT;
                end
            end
            oale_pkg::ST_INS_PUT: begin
                cmd.wr_put  = 1'b1;
                cmd.inc_cnt = 1'b1;
                state_next  = oale_pkg::ST_RESULT;
            end
            // move entries down one place, bottom first
            oale_pkg::ST_DEL_WALK: begin
                cmd.wr_shift = sts.pend_valid;
                if (sts.walk_more) begin
                    cmd.step = 1'b1;
                end else begin
                    cmd.dec_cnt = 1'b1;
                    state_next  = oale_pkg::ST_RESULT;
                end
            end
            // compare one entry per cycle, first hit wins
            oale_pkg::ST_SRCH: begin
                priority if (sts.pend_valid && sts.match) begin
                    cmd.cap_idx = 1'b1;
                    status_next = oale_pkg::STAT_OK;
                    state_next  = oale_pkg::ST_RESULT;
                end else if (sts.walk_more) begin
                    cmd.step = 1'b1;
                end else if (!sts.pend_valid) begin
                    status_next = oale_pkg::STAT_NOT_FOUND;
                    state_next  = oale_pkg::ST_RESULT;
                end else begin
                    state_next = oale_pkg::ST_SRCH;
                end
            end
            oale_pkg::ST_RD_WAIT: begin
                cmd.cap_rd = 1'b1;
                state_next = oale_pkg::ST_RESULT;
            end
            // hand the result to the output register once it is free
            oale_pkg::ST_RESULT: begin
                if (sts.out_free) begin
                    cmd.res_load = 1'b1;
                    state_next   = oale_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = oale_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/ordered_array_list_engine_top.sv -----
`timescale 1ns / 1ps
// Ordered array list engine: a list of signed 32-bit entries with a fill count.
// Input beats (s_ group) carry one operation: s_tuser selects insert, delete,
// overwrite, search or read, s_tdata carries the position and the value.
// Every input beat gives exactly one result beat (m_ group) with a status on
// m_tuser and the found index, read value and entry count on m_tdata.
// Operations run one at a time over an entry memory with a single write port
// that moves or compares one entry per cycle. The longest operation is a
// missed search of a full list, and the next beat is taken only once the
// controller is back in idle.
// s_tready is high only while no operation is in progress; a finished result
// sits in the output register, so the next beat is taken while it waits.
// When the receiver stalls, the result holds and a following operation
// completes internally but waits before loading its result.
// Reset (aresetn low, synchronous) empties the list and drops any result;
// entry contents are not cleared, since positions at or above the count are
// never read. Depends on oale_pkg, oale_ctrl, oale_dpath and assert_macros.svh

`include "assert_macros.svh"

module ordered_array_list_engine_top #(
    parameter int unsigned LIST_DEPTH = oale_pkg::LIST_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // position [7:0], value [39:8]
    input  logic [2:0]  s_tuser,   // mode [2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // found_index [7:0], read_value [39:8],
                                   // entry_count [48:40], zero [55:49]
    output logic [1:0]  m_tuser    // status [1:0]
);

    oale_pkg::cmd_t     cmd;
    oale_pkg::sts_t     sts;
    logic [7:0]         found_index;
    logic signed [31:0] read_value;
    logic [8:0]         entry_count;

    // sequencer
    oale_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // storage and result path
    oale_dpath #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_mode       (s_tuser),
        .in_pos        (s_tdata[7:0]),
        .in_val        (s_tdata[39:8]),
        .cmd           (cmd),
        .sts           (sts),
        .m_tready      (m_tready),
        .m_tvalid      (m_tvalid),
        .m_status      (m_tuser),
        .m_found_index (found_index),
        .m_read_value  (read_value),
        .m_entry_count (entry_count)
    );

    // pack the result beat
    assign m_tdata = {7'b0, entry_count, read_value, found_index};

    // checks on the sequencing
    `ASSERT_CLK(a_one_op_at_a_time, aclk, aresetn, s_tvalid && s_tready |=> !s_tready)
    `ASSERT_NEVER(a_single_write, aclk, aresetn, cmd.wr_shift && cmd.wr_put)
    `ASSERT_CLK(a_result_slot_free, aclk, aresetn, cmd.res_load |-> sts.out_free)
    `ASSERT_CLK(a_no_overfill, aclk, aresetn, cmd.inc_cnt |-> !sts.full)

endmodule
